// File: hdl/dll_pkg.sv
// Package: types, constants and codes for the doubly linked list engine.
`timescale 1ns / 1ps
package dll_pkg;
  localparam int unsigned Depth       = 16;
  localparam int unsigned SearchLimit = 10;
  localparam int unsigned IdxW        = $clog2(Depth);
  localparam int unsigned LinkW       = $clog2(Depth + 1);
  localparam int unsigned CntW        = $clog2(Depth + 1);
  localparam int unsigned StepW       = $clog2(SearchLimit + 1);
  localparam logic [LinkW-1:0] NilLink = LinkW'(Depth);

  localparam logic [2:0] CmdPushFront = 3'd0;
  localparam logic [2:0] CmdPushBack  = 3'd1;
  localparam logic [2:0] CmdInsAfter  = 3'd2;
  localparam logic [2:0] CmdPopFront  = 3'd3;
  localparam logic [2:0] CmdPopBack   = 3'd4;
  localparam logic [2:0] CmdDelKey    = 3'd5;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StEmpty    = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam logic [1:0] PlHead   = 2'd0;
  localparam logic [1:0] PlTail   = 2'd1;
  localparam logic [1:0] PlMiddle = 2'd2;
  localparam logic [1:0] PlNone   = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [1:0]         match_place;
    logic [4:0]         element_count;
  } out_beat_t;

  // one port of the node store: read address, optional write
  typedef struct packed {
    logic [IdxW-1:0]  raddr;
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [31:0]      wval;
    logic             wval_en;
    logic [LinkW-1:0] wnext;
    logic             wnext_en;
    logic [LinkW-1:0] wprev;
    logic             wprev_en;
  } mem_req_t;

  typedef struct packed {
    logic [31:0]      val;
    logic [LinkW-1:0] next;
    logic [LinkW-1:0] prev;
  } mem_rsp_t;
endpackage

// File: hdl/dll_node_mem.sv
// Node store: value, next and prev memories, one registered read a cycle.
`timescale 1ns / 1ps
module dll_node_mem (
  input  logic              clk_i,
  input  dll_pkg::mem_req_t req_i,
  output dll_pkg::mem_rsp_t rsp_o
);
  import dll_pkg::*;

  logic [31:0]      val_mem  [Depth];
  logic [LinkW-1:0] next_mem [Depth];
  logic [LinkW-1:0] prev_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we && req_i.wval_en) val_mem[req_i.waddr] <= req_i.wval;
    if (req_i.we && req_i.wnext_en) next_mem[req_i.waddr] <= req_i.wnext;
    if (req_i.we && req_i.wprev_en) prev_mem[req_i.waddr] <= req_i.wprev;
    rsp_o.val  <= val_mem[req_i.raddr];
    rsp_o.next <= next_mem[req_i.raddr];
    rsp_o.prev <= prev_mem[req_i.raddr];
  end
endmodule

// File: hdl/doubly_linked_list_engine_top.sv
// Top level: command sequencer for the doubly linked list engine.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_valid_i/in_ready_o | in_data_i  (cmd, key, value)
//  out     | out | out_valid_o/out_ready_i | out_data_o (status, removed, place, count)
//
// One command at a time. Push writes the new node on accept, then links its neighbour
// (no neighbour in an empty list). Pop reads the end node (SRead, SCheck), then relinks.
// Key commands read each node visited in SRead and SCheck (up to SearchLimit), then relink
// in SUpd1, and SUpd2 where a next node remains; a miss reports straight after the walk.
// Reset clears head, tail, count and the slot map; node memories need none.
// Input is ready only in idle with the output register free or draining that cycle.
`timescale 1ns / 1ps
module doubly_linked_list_engine_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dll_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dll_pkg::out_beat_t out_data_o
);
  import dll_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1; // address presented, wait for data
  localparam logic [2:0] SCheck = 3'd2; // node data available
  localparam logic [2:0] SUpd1  = 3'd3;
  localparam logic [2:0] SUpd2  = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0]       state_q, state_d;
  in_beat_t         cmd_q, cmd_d;
  logic [Depth-1:0] used_q, used_d;
  logic [LinkW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [LinkW-1:0] cur_q, cur_d;     // node under examination
  logic [StepW-1:0] step_q, step_d;
  logic [LinkW-1:0] nx_q, nx_d, pv_q, pv_d;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic [1:0]       place_q, place_d;
  logic [31:0]      rem_q, rem_d;
  logic             ovalid_q, ovalid_d;
  out_beat_t        odata_q, odata_d;

  mem_req_t req;
  mem_rsp_t rsp;

  dll_node_mem u_mem (.clk_i(clk_i), .req_i(req), .rsp_o(rsp));

  logic [IdxW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!used_q[i]) free_slot = IdxW'(i);
    end
  end

  logic empty, full, can_take;
  assign empty    = (head_q == NilLink);
  assign full     = (count_q == CntW'(Depth));
  assign can_take = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle) && can_take;

  function automatic logic [1:0] place_of(logic [LinkW-1:0] p, logic [LinkW-1:0] h,
                                          logic [LinkW-1:0] t);
    logic [1:0] r;
    if (p == h) r = PlHead;
    else if (p == t) r = PlTail;
    else r = PlMiddle;
    return r;
  endfunction

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; used_d = used_q; head_d = head_q; tail_d = tail_q;
    count_d = count_q; cur_d = cur_q; step_d = step_q; nx_d = nx_q; pv_d = pv_q;
    slot_d = slot_q; place_d = place_q; rem_d = rem_q;
    ovalid_d = ovalid_q && !out_ready_i; odata_d = odata_q;
    req = '0;
    req.raddr = cur_q[IdxW-1:0];

    case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_d   = in_data_i;
          place_d = PlNone;
          rem_d   = '0;
          slot_d  = free_slot;
          step_d  = '0;
          case (in_data_i.cmd)
            CmdPushFront, CmdPushBack: begin
              if (full) begin
                odata_d = '{StFull, 32'sd0, PlNone, 5'(count_q)};
                ovalid_d = 1'b1;
              end else begin
                // write the new node now, link its neighbour next cycle
                req.we = 1'b1; req.waddr = free_slot; req.wval = in_data_i.value;
                req.wval_en = 1'b1; req.wnext_en = 1'b1; req.wprev_en = 1'b1;
                req.wnext = NilLink; req.wprev = NilLink;
                used_d[free_slot] = 1'b1;
                count_d = count_q + 1'b1;
                if (empty) begin
                  head_d = LinkW'(free_slot); tail_d = LinkW'(free_slot);
                  state_d = SDone;
                end else if (in_data_i.cmd == CmdPushFront) begin
                  req.wnext = head_q;
                  head_d = LinkW'(free_slot);
                  cur_d = head_q;
                  state_d = SUpd1;
                end else begin
                  req.wprev = tail_q;
                  tail_d = LinkW'(free_slot);
                  cur_d = tail_q;
                  state_d = SUpd1;
                end
              end
            end
            CmdInsAfter, CmdPopFront, CmdPopBack, CmdDelKey: begin
              if (empty) begin
                odata_d = '{StEmpty, 32'sd0, PlNone, 5'(count_q)};
                ovalid_d = 1'b1;
              end else if (in_data_i.cmd == CmdInsAfter && full) begin
                odata_d = '{StFull, 32'sd0, PlNone, 5'(count_q)};
                ovalid_d = 1'b1;
              end else begin
                cur_d = (in_data_i.cmd == CmdPopBack) ? tail_q : head_q;
                state_d = SRead;
              end
            end
            default: begin
              odata_d = '{StOk, 32'sd0, PlNone, 5'(count_q)};
              ovalid_d = 1'b1;
            end
          endcase
        end
      end
      SRead: begin
        state_d = SCheck;
      end
      SCheck: begin
        nx_d = rsp.next; pv_d = rsp.prev; rem_d = rsp.val;
        if (cmd_q.cmd == CmdPopFront || cmd_q.cmd == CmdPopBack ||
            rsp.val == cmd_q.key) begin
          if (cmd_q.cmd == CmdInsAfter) begin
            place_d = place_of(cur_q, head_q, tail_q);
            rem_d = '0;
            // new node sits between cur and its next
            req.we = 1'b1; req.waddr = slot_q; req.wval = cmd_q.value;
            req.wval_en = 1'b1; req.wnext_en = 1'b1; req.wprev_en = 1'b1;
            req.wnext = rsp.next; req.wprev = cur_q;
            used_d[slot_q] = 1'b1;
            count_d = count_q + 1'b1;
            state_d = SUpd1;
          end else begin
            if (cmd_q.cmd == CmdDelKey) place_d = place_of(cur_q, head_q, tail_q);
            used_d[cur_q[IdxW-1:0]] = 1'b0;
            count_d = count_q - 1'b1;
            state_d = SUpd1;
          end
        end else if (rsp.next == NilLink || step_q == StepW'(SearchLimit - 1)) begin
          odata_d = '{StNotFound, 32'sd0, PlNone, 5'(count_q)};
          ovalid_d = 1'b1;
          state_d = SIdle;
        end else begin
          step_d = step_q + 1'b1;
          cur_d = rsp.next;
          state_d = SRead;
        end
      end
      SUpd1: begin
        state_d = SDone;
        case (cmd_q.cmd)
          CmdPushFront: begin
            req.we = 1'b1; req.waddr = cur_q[IdxW-1:0];
            req.wprev_en = 1'b1; req.wprev = LinkW'(slot_q);
          end
          CmdPushBack: begin
            req.we = 1'b1; req.waddr = cur_q[IdxW-1:0];
            req.wnext_en = 1'b1; req.wnext = LinkW'(slot_q);
          end
          CmdInsAfter: begin
            req.we = 1'b1; req.waddr = cur_q[IdxW-1:0];
            req.wnext_en = 1'b1; req.wnext = LinkW'(slot_q);
            if (nx_q == NilLink) tail_d = LinkW'(slot_q);
            else state_d = SUpd2;
          end
          default: begin
            // unlink: fix prev's next, then next's prev
            if (pv_q == NilLink) head_d = nx_q;
            else begin
              req.we = 1'b1; req.waddr = pv_q[IdxW-1:0];
              req.wnext_en = 1'b1; req.wnext = nx_q;
            end
            if (nx_q == NilLink) tail_d = pv_q;
            else state_d = SUpd2;
          end
        endcase
      end
      SUpd2: begin
        req.we = 1'b1; req.waddr = nx_q[IdxW-1:0]; req.wprev_en = 1'b1;
        req.wprev = (cmd_q.cmd == CmdInsAfter) ? LinkW'(slot_q) : pv_q;
        state_d = SDone;
      end
      SDone: begin
        if (can_take) begin
          odata_d = '{StOk, rem_q, place_q, 5'(count_q)};
          ovalid_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; used_q <= '0; head_q <= NilLink; tail_q <= NilLink;
      count_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; used_q <= used_d; head_q <= head_d; tail_q <= tail_d;
      count_q <= count_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; cur_q <= cur_d; step_q <= step_d; nx_q <= nx_d; pv_q <= pv_d;
    slot_q <= slot_d; place_q <= place_d; rem_q <= rem_d; odata_q <= odata_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

`ifndef SYNTHESIS
  a_count_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(count_q)) else $error("slot map and count disagree");
  a_empty_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NilLink) == (tail_q == NilLink)) else $error("head and tail nil mismatch");
  // count drops in the cycle before head moves, so check only between commands
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> ((head_q == NilLink) == (count_q == '0)))
    else $error("empty list with nonzero count");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped");
`endif
endmodule

// File: verif/doubly_linked_list_engine_top_test.sv
// Testbench: directed table plus random command streams, checked against a list predictor.
`timescale 1ns / 1ps
module doubly_linked_list_engine_top_test;
  import dll_pkg::*;

  localparam int unsigned NumRandom  = 1800;
  localparam int unsigned StallLimit = 20000;
  localparam logic [2:0]  CmdUnused6 = 3'd6;
  localparam logic [2:0]  CmdUnused7 = 3'd7;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;

  doubly_linked_list_engine_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor state: list contents from head to tail, slot per node
  logic signed [31:0] list_vals[$];
  int unsigned        list_slots[$];
  logic [Depth-1:0]   slot_busy;

  out_beat_t result_queue[$];
  out_beat_t predicted;
  int unsigned errors;
  int unsigned idle_cycles;
  bit          stim_done;

  function automatic int unsigned lowest_free_slot();
    for (int unsigned i = 0; i < Depth; i++) begin
      if (!slot_busy[i]) return i;
    end
    return Depth;
  endfunction

  function automatic int find_within_reach(logic signed [31:0] k);
    for (int i = 0; i < list_vals.size() && i < SearchLimit; i++) begin
      if (list_vals[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic logic [1:0] place_at(int pos);
    if (pos == 0) return PlHead;
    if (pos == list_vals.size() - 1) return PlTail;
    return PlMiddle;
  endfunction

  function automatic out_beat_t apply_command(in_beat_t c);
    out_beat_t   r;
    int          pos;
    int unsigned s;
    r.status        = StOk;
    r.removed_value = '0;
    r.match_place   = PlNone;
    case (c.cmd)
      CmdPushFront, CmdPushBack: begin
        if (list_vals.size() >= Depth) begin
          r.status = StFull;
        end else begin
          s = lowest_free_slot();
          slot_busy[s] = 1'b1;
          if (c.cmd == CmdPushFront) begin
            list_vals.push_front(c.value);
            list_slots.push_front(s);
          end else begin
            list_vals.push_back(c.value);
            list_slots.push_back(s);
          end
        end
      end
      CmdInsAfter: begin
        if (list_vals.size() == 0) r.status = StEmpty;
        else if (list_vals.size() >= Depth) r.status = StFull;
        else begin
          pos = find_within_reach(c.key);
          if (pos < 0) r.status = StNotFound;
          else begin
            r.match_place = place_at(pos);
            s = lowest_free_slot();
            slot_busy[s] = 1'b1;
            list_vals.insert(pos + 1, c.value);
            list_slots.insert(pos + 1, s);
          end
        end
      end
      CmdPopFront, CmdPopBack, CmdDelKey: begin
        if (list_vals.size() == 0) r.status = StEmpty;
        else begin
          if (c.cmd == CmdPopFront) pos = 0;
          else if (c.cmd == CmdPopBack) pos = list_vals.size() - 1;
          else pos = find_within_reach(c.key);
          if (pos < 0) begin
            r.status = StNotFound;
          end else begin
            if (c.cmd == CmdDelKey) r.match_place = place_at(pos);
            r.removed_value = list_vals[pos];
            slot_busy[list_slots[pos]] = 1'b0;
            list_vals.delete(pos);
            list_slots.delete(pos);
          end
        end
      end
      default: ;
    endcase
    r.element_count = 5'(list_vals.size());
    return r;
  endfunction

  task automatic offer_command(in_beat_t c);
    int unsigned gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    result_queue.push_back(apply_command(c));
    @(negedge clk_i);
  endtask

  function automatic in_beat_t make_beat(logic [2:0] c, logic signed [31:0] k,
                                         logic signed [31:0] v);
    in_beat_t b;
    b.cmd   = c;
    b.key   = k;
    b.value = v;
    return b;
  endfunction

  // draws from a small pool so keys hit often
  function automatic logic signed [31:0] pool_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 11);
  endfunction

  // directed table: command, key, value, typed result where obvious
  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } row_t;

  row_t table_rows[$];

  function automatic out_beat_t res(logic [1:0] st, logic signed [31:0] rv,
                                    logic [1:0] pl, int unsigned n);
    out_beat_t r;
    r.status        = st;
    r.removed_value = rv;
    r.match_place   = pl;
    r.element_count = 5'(n);
    return r;
  endfunction

  task automatic add_row(logic [2:0] c, logic signed [31:0] k, logic signed [31:0] v,
                         bit typed = 1'b0, out_beat_t w = '0);
    row_t r;
    r.beat  = make_beat(c, k, v);
    r.typed = typed;
    r.want  = w;
    table_rows.push_back(r);
  endtask

  initial begin
    logic [2:0] c;
    int unsigned pick;
    errors      = 0;
    stim_done   = 1'b0;
    slot_busy   = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list on every command that needs a node
    add_row(CmdPopFront, 0, 0, 1'b1, res(StEmpty, 0, PlNone, 0));
    add_row(CmdPopBack, 0, 0, 1'b1, res(StEmpty, 0, PlNone, 0));
    add_row(CmdDelKey, 5, 0, 1'b1, res(StEmpty, 0, PlNone, 0));
    add_row(CmdInsAfter, 5, 1, 1'b1, res(StEmpty, 0, PlNone, 0));
    add_row(CmdUnused6, -1, -1, 1'b1, res(StOk, 0, PlNone, 0));
    add_row(CmdPushBack, 0, 32'sh7fffffff, 1'b1, res(StOk, 0, PlNone, 1));
    add_row(CmdPopFront, 0, 0, 1'b1, res(StOk, 32'sh7fffffff, PlNone, 0));
    add_row(CmdPushFront, 0, 32'sh80000000, 1'b1, res(StOk, 0, PlNone, 1));
    add_row(CmdDelKey, 32'sh80000000, 0, 1'b1, res(StOk, 32'sh80000000, PlHead, 0));
    for (int i = 0; i < Depth; i++) add_row(CmdPushBack, 0, i);
    add_row(CmdPushFront, 0, 99, 1'b1, res(StFull, 0, PlNone, Depth));
    add_row(CmdInsAfter, 0, 99, 1'b1, res(StFull, 0, PlNone, Depth));
    add_row(CmdDelKey, 12, 0, 1'b1, res(StNotFound, 0, PlNone, Depth));
    add_row(CmdDelKey, 15, 0);
    add_row(CmdDelKey, 3, 0);
    add_row(CmdInsAfter, 9, -5);
    add_row(CmdUnused7, 0, 0);
    add_row(CmdPopBack, 0, 0);

    foreach (table_rows[i]) begin
      offer_command(table_rows[i].beat);
      if (table_rows[i].typed && result_queue[$] != table_rows[i].want) begin
        $display("%0t table row %0d: expected %p, predictor gave %p", $time, i,
                 table_rows[i].want, result_queue[$]);
        errors++;
      end
    end

    for (int n = 0; n < NumRandom; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) c = (pick < 15) ? CmdPushFront : CmdPushBack;
      else if (pick < 48) c = CmdInsAfter;
      else if (pick < 62) c = CmdPopFront;
      else if (pick < 76) c = CmdPopBack;
      else if (pick < 97) c = CmdDelKey;
      else c = 3'($urandom_range(6, 7));
      offer_command(make_beat(c, pool_value(), pool_value()));
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: own stall pattern plus one long hold-off
  initial begin
    int unsigned phase;
    out_ready_i = 1'b0;
    phase       = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      phase++;
      if (phase == 300) begin
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      if ((phase / 64) % 3 == 2) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_queue.size() == 0) begin
        $display("%0t unexpected beat: actual %p", $time, out_data_o);
        errors++;
      end else begin
        predicted = result_queue.pop_front();
        if (out_data_o.status !== predicted.status)
          $display("%0t status: expected %0d actual %0d", $time,
                   predicted.status, out_data_o.status);
        if (out_data_o.removed_value !== predicted.removed_value)
          $display("%0t removed_value: expected %0d actual %0d", $time,
                   predicted.removed_value, out_data_o.removed_value);
        if (out_data_o.match_place !== predicted.match_place)
          $display("%0t match_place: expected %0d actual %0d", $time,
                   predicted.match_place, out_data_o.match_place);
        if (out_data_o.element_count !== predicted.element_count)
          $display("%0t element_count: expected %0d actual %0d", $time,
                   predicted.element_count, out_data_o.element_count);
        if (out_data_o !== predicted) errors++;
      end
    end
  end

  // watchdog and end of run
  initial begin
    idle_cycles = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
      if (stim_done && result_queue.size() == 0) begin
        repeat (50) @(posedge clk_i);
        if (errors == 0 && result_queue.size() == 0 && !out_valid_o) begin
          $display("RESULT: OK");
        end else begin
          $display("RESULT: ERROR");
        end
        $finish;
      end
    end
  end
endmodule
